// ===== rtl/nfa_string_recognizer_assert.svh =====
// ----------------------------------------------------------------------------
// nfa_string_recognizer assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NFA_STRING_RECOGNIZER_ASSERT_SVH
`define NFA_STRING_RECOGNIZER_ASSERT_SVH

// antecedent implies consequent in the next cycle
`define NFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nfa_string_recognizer: assertion failed");

// antecedent implies consequent in the same cycle
`define NFA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nfa_string_recognizer: assertion failed");

`endif

// ===== rtl/nfa_pkg.sv =====
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared types and constants of the NFA string recogniser.
// ----------------------------------------------------------------------------
package nfa_pkg;

    localparam int DEF_MAX_STATES      = 32;
    localparam int DEF_MAX_TRANSITIONS = 64;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_NUM_STATES = 1'b0;
    localparam logic REG_NUM_TRANS  = 1'b1;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_SYMBOL = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] slot;
        logic [4:0] from_state;
        logic [4:0] to_state;
        logic [7:0] symbol;
    } t_in;

    typedef struct packed {
        logic        accepted;
        logic [15:0] length;
    } t_out;

    typedef struct packed {
        logic [4:0] from_state;
        logic [4:0] to_state;
        logic [7:0] symbol;
    } t_entry;

endpackage

// ===== rtl/nfa_table.sv =====
// ----------------------------------------------------------------------------
// nfa_table
// Transition table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nfa_table #(
    parameter int MAX_TRANSITIONS = nfa_pkg::DEF_MAX_TRANSITIONS
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [((MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1)-1:0] i_wr_addr,
    input  nfa_pkg::t_entry i_wr_data,
    input  logic            i_rd_en,
    input  logic [((MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1)-1:0] i_rd_addr,
    output nfa_pkg::t_entry o_rd_data
);
    import nfa_pkg::*;

    t_entry r_mem [MAX_TRANSITIONS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/nfa_engine.sv =====
// ----------------------------------------------------------------------------
// nfa_engine
// Request decode, table scan sequencer, active state set and result register.
// ----------------------------------------------------------------------------
module nfa_engine #(
    parameter int MAX_STATES      = nfa_pkg::DEF_MAX_STATES,
    parameter int MAX_TRANSITIONS = nfa_pkg::DEF_MAX_TRANSITIONS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [$clog2(MAX_STATES+1)-1:0]      i_n_states,
    input  logic [$clog2(MAX_TRANSITIONS+1)-1:0] i_n_entries,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  nfa_pkg::t_in    i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output nfa_pkg::t_out   o_out,
    output logic            o_wr_en,
    output logic [((MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1)-1:0] o_wr_addr,
    output nfa_pkg::t_entry o_wr_data,
    output logic            o_rd_en,
    output logic [((MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1)-1:0] o_rd_addr,
    input  nfa_pkg::t_entry i_rd_data
);
    import nfa_pkg::*;

    localparam int AW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
    localparam int CW = $clog2(MAX_TRANSITIONS + 1);
    localparam int SW = $clog2(MAX_STATES + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state                r_state;
    logic [MAX_STATES-1:0] r_act;
    logic                  r_alive;
    logic [15:0]           r_count;
    logic [7:0]            r_sym;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_lim;
    logic                  r_pend;
    logic [MAX_STATES-1:0] r_next;
    logic [MAX_STATES-1:0] n_next;
    logic                  r_fired;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_out                  r_out;

    logic                  w_accept;
    logic                  w_from_act;
    logic                  w_hit;
    logic                  w_to_ok;
    logic                  w_verdict;
    logic [SW-1:0]         w_last;

    assign o_in_ready = (r_state == ST_IDLE) &&
                        ((i_in.mode != MODE_FINISH) || !r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    assign o_wr_en   = w_accept && (i_in.mode == MODE_LOAD) &&
                       (32'(i_in.slot) < MAX_TRANSITIONS);
    assign o_wr_addr = AW'(i_in.slot);
    assign o_wr_data = '{from_state: i_in.from_state, to_state: i_in.to_state,
                         symbol: i_in.symbol};

    assign o_rd_en   = (r_state == ST_SCAN) && (r_idx < r_lim);
    assign o_rd_addr = r_idx[AW-1:0];

    assign w_from_act = |(r_act & (MAX_STATES'(1) << i_rd_data.from_state));
    assign w_hit      = r_pend && (i_rd_data.symbol == r_sym) &&
                        (32'(i_rd_data.from_state) < 32'(i_n_states)) && w_from_act;
    assign w_to_ok    = 32'(i_rd_data.to_state) < 32'(i_n_states);

    always_comb begin
        n_next = r_next;
        if (w_hit && w_to_ok) begin
            n_next = r_next | (MAX_STATES'(1) << i_rd_data.to_state);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_accept && (i_in.mode == MODE_FINISH)) begin
            n_out_valid = 1'b1;
        end
    end

    assign w_last    = i_n_states - SW'(1);
    assign w_verdict = r_alive && |(r_act & (MAX_STATES'(1) << w_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_act       <= MAX_STATES'(1);
            r_alive     <= 1'b1;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (i_in.mode)
                            MODE_SYMBOL: begin
                                if (r_count != COUNT_MAX) begin
                                    r_count <= r_count + 16'd1;
                                end
                                r_sym   <= i_in.symbol;
                                r_idx   <= '0;
                                r_lim   <= r_alive ? i_n_entries : '0;
                                r_pend  <= 1'b0;
                                r_next  <= '0;
                                r_fired <= 1'b0;
                                r_state <= ST_SCAN;
                            end
                            MODE_FINISH: begin
                                r_out       <= '{accepted: w_verdict, length: r_count};
                                r_act       <= MAX_STATES'(1);
                                r_alive     <= 1'b1;
                                r_count     <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    r_pend  <= o_rd_en;
                    r_next  <= n_next;
                    r_fired <= r_fired | w_hit;
                    if (o_rd_en) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (!o_rd_en && !r_pend) begin
                        r_act   <= r_next;
                        r_alive <= r_alive && r_fired;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/nfa_string_recognizer.sv =====
// Load request: written to the table on acceptance. Finish request: result valid the next cycle.
// Symbol request: the table read port scans the m valid table entries (m = num_transitions,
// capped) one entry per cycle; each entry is checked when its registered read data returns,
// then the new set is committed. No entries are scanned when m is 0 or the run is dead.
// One request at a time; a finish also waits while the result register is full and unread.
// Reset (synchronous, i_rst_n low): state 0 active, run alive, count 0,
// ----------------------------------------------------------------------------
// nfa_string_recognizer
// NFA string recogniser with an APB register port and a transition table memory.
// Reset also sets num_states 1, num_transitions 0; table undefined until loaded.
// ----------------------------------------------------------------------------
`include "nfa_string_recognizer_assert.svh"

module nfa_string_recognizer #(
    parameter int MAX_STATES      = nfa_pkg::DEF_MAX_STATES,
    parameter int MAX_TRANSITIONS = nfa_pkg::DEF_MAX_TRANSITIONS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [nfa_pkg::APB_AW-1:0] paddr,
    input  logic [nfa_pkg::APB_DW-1:0] pwdata,
    output logic [nfa_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  nfa_pkg::t_in               i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output nfa_pkg::t_out              o_out
);
    import nfa_pkg::*;

    localparam int AW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
    localparam int CW = $clog2(MAX_TRANSITIONS + 1);
    localparam int SW = $clog2(MAX_STATES + 1);

    logic [5:0]    r_num_states;
    logic [6:0]    r_num_trans;
    logic [SW-1:0] w_n_states;
    logic [CW-1:0] w_n_entries;

    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_entry        w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_entry        w_rd_data;

    logic          w_sym_acc;
    logic          w_fin_acc;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_states <= 6'd1;
            r_num_trans  <= 7'd0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_NUM_STATES: r_num_states <= pwdata[5:0];
                REG_NUM_TRANS:  r_num_trans  <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_NUM_STATES: prdata = APB_DW'(r_num_states);
            REG_NUM_TRANS:  prdata = APB_DW'(r_num_trans);
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        if (r_num_states == 6'd0) begin
            w_n_states = SW'(1);
        end else if (32'(r_num_states) > MAX_STATES) begin
            w_n_states = SW'(MAX_STATES);
        end else begin
            w_n_states = SW'(r_num_states);
        end
    end

    assign w_n_entries = (32'(r_num_trans) > MAX_TRANSITIONS) ? CW'(MAX_TRANSITIONS)
                                                               : CW'(r_num_trans);

    nfa_table #(
        .MAX_TRANSITIONS (MAX_TRANSITIONS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    nfa_engine #(
        .MAX_STATES      (MAX_STATES),
        .MAX_TRANSITIONS (MAX_TRANSITIONS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_n_states  (w_n_states),
        .i_n_entries (w_n_entries),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    assign w_sym_acc = i_in_valid && o_in_ready && (i_in.mode == MODE_SYMBOL);
    assign w_fin_acc = i_in_valid && o_in_ready && (i_in.mode == MODE_FINISH);

    `NFA_ASSERT_NEXT(a_symbol_blocks, w_sym_acc, !o_in_ready)
    `NFA_ASSERT_NEXT(a_finish_result, w_fin_acc, o_out_valid)
    `NFA_ASSERT_NOW(a_result_source, $rose(o_out_valid), $past(w_fin_acc))

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: NFA string recogniser testbench
// Drives load, symbol and finish requests into nfa_string_recognizer, keeps a
// bit-set model of the automaton in step with every accepted request and
// checks each verdict and length against it. Directed tests cover the empty
// string, dead runs, out-of-range destinations and registers and the unused
// mode. Random phases run guided strings under input idling and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    import nfa_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int NUM_SLOTS   = DEF_MAX_TRANSITIONS;
    localparam int STATE_LIMIT = DEF_MAX_STATES;
    localparam int DRAIN_TAIL  = 80;
    localparam int PHASE_ITEMS = 80;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in                 i_in;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out                o_out;

    t_entry              trans_tbl [NUM_SLOTS];
    logic [31:0]         active_states;
    logic                run_alive;
    logic [15:0]         sym_count;
    logic [5:0]          cfg_states;
    logic [6:0]          cfg_trans;
    t_out                verdict_q [$];
    int                  err_cnt;
    int                  send_idle_pct;
    int                  recv_stall_pct;

    nfa_string_recognizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int states_in_use();
        if (cfg_states == 6'd0) return 1;
        if (cfg_states > STATE_LIMIT) return STATE_LIMIT;
        return int'(cfg_states);
    endfunction

    function automatic int entries_in_use();
        if (cfg_trans > NUM_SLOTS) return NUM_SLOTS;
        return int'(cfg_trans);
    endfunction

    task automatic recognise_step(input t_in req);
        int          ns;
        logic [31:0] next_set;
        logic        fired;
        t_out        verdict;
        ns = states_in_use();
        case (req.mode)
            MODE_LOAD: begin
                trans_tbl[req.slot] = '{req.from_state, req.to_state, req.symbol};
            end
            MODE_SYMBOL: begin
                if (sym_count != COUNT_MAX) sym_count++;
                if (run_alive) begin
                    next_set = '0;
                    fired    = 1'b0;
                    for (int t = 0; t < entries_in_use(); t++) begin
                        if (trans_tbl[t].symbol == req.symbol &&
                            int'(trans_tbl[t].from_state) < ns &&
                            active_states[trans_tbl[t].from_state]) begin
                            fired = 1'b1;
                            if (int'(trans_tbl[t].to_state) < ns)
                                next_set[trans_tbl[t].to_state] = 1'b1;
                        end
                    end
                    active_states = next_set;
                    if (!fired) run_alive = 1'b0;
                end
            end
            MODE_FINISH: begin
                verdict.accepted = run_alive && active_states[ns-1];
                verdict.length   = sym_count;
                verdict_q.push_back(verdict);
                active_states = 32'd1;
                run_alive     = 1'b1;
                sym_count     = '0;
            end
            default: ;
        endcase
    endtask

    task automatic send_request(input t_in req);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in       = req;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        recognise_step(req);
    endtask

    function automatic t_in random_request(input logic [1:0] mode);
        t_in req;
        req            = t_in'($bits(t_in)'($urandom));
        req.mode       = mode;
        return req;
    endfunction

    task automatic send_load(input logic [5:0] slot, input logic [4:0] from_st,
                             input logic [4:0] to_st, input logic [7:0] sym);
        t_in req;
        req = '{MODE_LOAD, slot, from_st, to_st, sym};
        send_request(req);
    endtask

    task automatic send_symbol(input logic [7:0] sym);
        t_in req;
        req        = random_request(MODE_SYMBOL);
        req.symbol = sym;
        send_request(req);
    endtask

    task automatic send_finish();
        send_request(random_request(MODE_FINISH));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (verdict_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_NUM_STATES) cfg_states = value[5:0];
        else cfg_trans = value[6:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_out exp_v;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected result: accepted %0d length %0d",
                       o_out.accepted, o_out.length);
                err_cnt++;
            end else begin
                exp_v = verdict_q.pop_front();
                if (o_out.accepted !== exp_v.accepted) begin
                    $error("accepted: expected %0d, got %0d", exp_v.accepted,
                           o_out.accepted);
                    err_cnt++;
                end
                if (o_out.length !== exp_v.length) begin
                    $error("length: expected %0d, got %0d", exp_v.length,
                           o_out.length);
                    err_cnt++;
                end
            end
        end
    end

    task automatic test_empty_string();
        send_finish();
        drain();
        cfg_write(REG_NUM_STATES, 32'd0);
        send_finish();
        drain();
        cfg_write(REG_NUM_STATES, 32'd2);
        send_finish();
        drain();
    endtask

    task automatic test_directed_strings();
        t_in noise;
        send_load(6'd0, 5'd0, 5'd1, 8'h61);
        send_load(6'd1, 5'd1, 5'd2, 8'h62);
        send_load(6'd2, 5'd1, 5'd31, 8'h62);
        send_load(6'd3, 5'd0, 5'd0, 8'h61);
        send_load(6'd4, 5'd0, 5'd31, 8'hFF);
        send_load(6'd63, 5'd31, 5'd31, 8'hFF);
        drain();
        cfg_write(REG_NUM_STATES, 32'd3);
        cfg_write(REG_NUM_TRANS, 32'd5);
        send_symbol(8'h61);
        send_symbol(8'h62);
        send_finish();
        send_symbol(8'h61);
        send_finish();
        send_symbol(8'h63);
        send_symbol(8'h61);
        send_symbol(8'h62);
        send_finish();
        noise = random_request(MODE_UNUSED);
        send_request(noise);
        send_symbol(8'h61);
        send_symbol(8'h61);
        send_symbol(8'h62);
        send_finish();
        drain();
        cfg_write(REG_NUM_STATES, 32'd63);
        send_symbol(8'hFF);
        send_finish();
        drain();
        cfg_write(REG_NUM_STATES, 32'd32);
        send_symbol(8'hFF);
        send_finish();
        drain();
    endtask

    task automatic fill_table();
        for (int s = 0; s < NUM_SLOTS; s++)
            send_load(6'(s), 5'($urandom), 5'($urandom),
                      ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : 8'($urandom));
    endtask

    task automatic send_guided_symbol();
        int          cand [$];
        logic [7:0]  sym;
        int          ns;
        ns = states_in_use();
        for (int t = 0; t < entries_in_use(); t++)
            if (run_alive && int'(trans_tbl[t].from_state) < ns &&
                active_states[trans_tbl[t].from_state])
                cand.push_back(t);
        if (cand.size() > 0 && $urandom_range(99) < 80)
            sym = trans_tbl[cand[$urandom_range(cand.size() - 1)]].symbol;
        else if ($urandom_range(99) < 80)
            sym = 8'($urandom_range(3));
        else
            sym = 8'($urandom);
        send_symbol(sym);
    endtask

    task automatic test_random_phases();
        int          state_picks [8];
        int          trans_picks [8];
        int          idle_picks  [4];
        int          stall_picks [4];
        int          sent;
        int          ns;
        int          nt;
        int          len;
        state_picks = '{3, 0, 32, 63, 2, 1, 5, 33};
        trans_picks = '{6, 64, 0, 127, 3, 65, 12, 1};
        idle_picks  = '{0, 78, 0, 8};
        stall_picks = '{0, 0, 78, 8};
        fill_table();
        drain();
        for (int ph = 0; ph < 8; ph++) begin
            cfg_write(REG_NUM_STATES, 32'(state_picks[ph]));
            cfg_write(REG_NUM_TRANS, 32'(trans_picks[ph]));
            send_idle_pct  = idle_picks[ph % 4];
            recv_stall_pct = stall_picks[ph % 4];
            ns = states_in_use();
            nt = entries_in_use();
            for (int k = 0; k < 10; k++)
                send_load((nt > 0) ? 6'($urandom_range(nt - 1)) : 6'($urandom),
                          ($urandom_range(9) > 0) ? 5'($urandom_range(ns - 1)) : 5'($urandom),
                          ($urandom_range(9) > 0) ? 5'($urandom_range(ns - 1)) : 5'($urandom),
                          ($urandom_range(9) > 0) ? 8'($urandom_range(3)) : 8'($urandom));
            sent = 10;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(99) < 10) begin
                    if ($urandom_range(1) == 0)
                        send_request(random_request(MODE_UNUSED));
                    else
                        send_request(random_request(MODE_LOAD));
                    sent++;
                end else begin
                    len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
                    repeat (len) send_guided_symbol();
                    send_finish();
                    sent += len + 1;
                end
            end
            drain();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        i_out_ready    = 1'b1;
        err_cnt        = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int s = 0; s < NUM_SLOTS; s++) trans_tbl[s] = '0;
        active_states  = 32'd1;
        run_alive      = 1'b1;
        sym_count      = '0;
        cfg_states     = 6'd1;
        cfg_trans      = 7'd0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_string();
        test_directed_strings();
        test_random_phases();

        if (err_cnt == 0 && verdict_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== nfa_string_recognizer.f =====
+incdir+rtl
rtl/nfa_pkg.sv
rtl/nfa_table.sv
rtl/nfa_engine.sv
rtl/nfa_string_recognizer.sv
dv/tb_top.sv
